// File: rtl/core/pfns_pkg.sv
// Shared types, hash constants and reciprocal table for the fractal noise sampler.
`timescale 1ns / 1ps

package pfns_pkg;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCALE = 5'b00010,
      ST_OCT   = 5'b00100,
      ST_MEAN  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef logic [4:0] step_type;

   localparam step_type S_SEED  = 5'd0;
   localparam step_type S_HX0   = 5'd1;
   localparam step_type S_HX1   = 5'd2;
   localparam step_type S_HY0   = 5'd3;
   localparam step_type S_HY1   = 5'd4;
   localparam step_type S_HASH0 = 5'd5;
   localparam step_type S_HASH1 = 5'd6;
   localparam step_type S_HASH2 = 5'd7;
   localparam step_type S_HASH3 = 5'd8;
   localparam step_type S_DIAG0 = 5'd9;
   localparam step_type S_DIAG1 = 5'd10;
   localparam step_type S_DIAG2 = 5'd11;
   localparam step_type S_DIAG3 = 5'd12;
   localparam step_type S_FX2   = 5'd13;
   localparam step_type S_FX3   = 5'd14;
   localparam step_type S_FXI   = 5'd15;
   localparam step_type S_FXU   = 5'd16;
   localparam step_type S_FY2   = 5'd17;
   localparam step_type S_FY3   = 5'd18;
   localparam step_type S_FYI   = 5'd19;
   localparam step_type S_FYV   = 5'd20;
   localparam step_type S_BLA   = 5'd21;
   localparam step_type S_BLB   = 5'd22;
   localparam step_type S_BLR   = 5'd23;
   localparam step_type S_OUT   = 5'd24;

   localparam logic [31:0] HASH_MUL_X    = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Y    = 32'd668265263;
   localparam logic [31:0] HASH_MUL_SEED = 32'd2147483647;
   localparam logic [31:0] HASH_MUL_MIX  = 32'd1274126177;
   localparam logic [31:0] OCTAVE_SEED_STEP = 32'd131;

   // The weighted sum stays below 2^40 for every legal octave count and fraction width.
   localparam int SUM_W = 41;
   localparam int SUM_SPLIT = 24;

   localparam logic [32:0] RECIP_TABLE [16] = '{
      33'd4294967296, 33'd1431655765, 33'd613566757, 33'd286331153,
      33'd138547332,  33'd68174084,   33'd33818640,  33'd16843009,
      33'd8405024,    33'd4198404,    33'd2098177,   33'd1048832,
      33'd524352,     33'd262160,     33'd131076,    33'd65537
   };

   localparam logic [1:0] GRAD_SX [8] = '{2'b01, 2'b11, 2'b00, 2'b00,
                                         2'b01, 2'b11, 2'b01, 2'b11};
   localparam logic [1:0] GRAD_SY [8] = '{2'b00, 2'b00, 2'b01, 2'b11,
                                         2'b01, 2'b01, 2'b11, 2'b11};

endpackage

// File: rtl/core/perlin_fbm_noise_sampler.sv
// Top level of the fractal 2D gradient noise sampler.
`timescale 1ns / 1ps

// One word in gives one word out. All products go through a single shared 34 by 34 bit
// signed multiplier under a step sequencer: the scale state scales both coordinates, each octave
// takes 25 multiplier steps, two more steps form the normalized mean and the done state loads
// the output register once it is free. The sequencer returns to idle as the result is loaded,
// so the next word can be accepted while the result waits. The input side
// accepts a new word only while the sequencer is idle; the result waits in its own output
// register.
module perlin_fbm_noise_sampler #(
   parameter int MAX_OCTAVES = 8,
   parameter int FRAC_BITS   = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // coord_x[31:0], coord_y[63:32], base_frequency[87:64], octave_count[91:88],
   // noise_seed[123:92], zero padding[127:124]
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // noise_value[15:0]
   output logic [15:0]  rsp_tdata
);

   localparam int QW = FRAC_BITS + 6;
   localparam int NW = $clog2(MAX_OCTAVES + 1);
   localparam longint DIAG_L = ((longint'(70710678) <<< FRAC_BITS) + 50000000) / 100000000;
   localparam logic signed [QW-1:0] Q_ONE  = QW'(longint'(1) <<< FRAC_BITS);
   localparam logic signed [QW-1:0] Q_HALF = QW'(longint'(1) <<< (FRAC_BITS - 1));
   localparam logic signed [QW-1:0] Q_DIAG = QW'(DIAG_L);
   localparam logic signed [67:0] RND_HALF = 68'(longint'(1) <<< (FRAC_BITS - 1));
   localparam int SH_DN = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
   localparam int SH_UP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam logic [63:0] OUT_RND = 64'((2 ** SH_DN) / 2);

   function automatic logic signed [QW-1:0] rq(input logic signed [67:0] p);
      logic signed [67:0] s;
      s = (p + RND_HALF) >>> FRAC_BITS;
      return s[QW-1:0];
   endfunction

   function automatic logic signed [QW-1:0] gsel(input logic [1:0] sg,
                                                 input logic signed [QW-1:0] v);
      logic signed [QW-1:0] r;
      case (sg)
         2'b01:   r = v;
         2'b11:   r = -v;
         default: r = '0;
      endcase
      return r;
   endfunction

   pfns_pkg::state_type state_ff, state_in;
   pfns_pkg::step_type  step_ff, step_in;
   logic [NW-1:0]       n_ff, n_in;
   logic [NW-1:0]       oct_ff, oct_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_data_ff;

   logic signed [31:0]  cx_ff, cy_ff;
   logic [23:0]         freq_ff;
   logic [31:0]         seed_ff;
   logic [63:0]         sx_ff, sy_ff;
   logic [31:0]         hs_ff;
   logic [31:0]         hx_ff [2];
   logic [31:0]         hy_ff [2];
   logic [2:0]          g_ff [4];
   logic signed [QW-1:0] d_ff [4];
   logic signed [QW-1:0] t2_ff, t3_ff, inner_ff, u_ff, v_ff, a_ff, b_ff, r_ff;
   logic [pfns_pkg::SUM_W-1:0] sum_ff;
   logic [79:0]         acc_ff;

   logic signed [33:0]  mul_a, mul_b;
   logic signed [67:0]  mul_p;
   logic signed [67:0]  scaled;
   logic signed [QW-1:0] rq_p;
   logic [31:0]         x0, y0;
   logic signed [QW-1:0] fx, fy, fade_t;
   logic [1:0]          hc, dc;
   logic [31:0]         hsum, hmix;
   logic signed [QW-1:0] dx, dy, dot;
   logic signed [QW-1:0] p_raw, p_clamp;
   logic [3:0]          oc_raw;
   logic [47:0]         mean;
   logic [63:0]         conv;
   logic                last_oct, rsp_free;

   assign mul_p  = mul_a * mul_b;
   assign scaled = mul_p >>> FRAC_BITS;
   assign rq_p   = rq(mul_p);

   assign x0 = sx_ff[FRAC_BITS+31:FRAC_BITS];
   assign y0 = sy_ff[FRAC_BITS+31:FRAC_BITS];
   assign fx = QW'({1'b0, sx_ff[FRAC_BITS-1:0]});
   assign fy = QW'({1'b0, sy_ff[FRAC_BITS-1:0]});
   assign fade_t = (step_ff >= pfns_pkg::S_FY2) ? fy : fx;

   assign hc   = 2'(step_ff - pfns_pkg::S_HASH0);
   assign dc   = 2'(step_ff - pfns_pkg::S_DIAG0);
   assign hsum = hx_ff[hc[0]] + hy_ff[hc[1]] + hs_ff;
   assign hmix = hsum ^ (hsum >> 13);

   assign dx  = dc[0] ? fx - Q_ONE : fx;
   assign dy  = dc[1] ? fy - Q_ONE : fy;
   assign dot = gsel(pfns_pkg::GRAD_SX[g_ff[dc]], dx) + gsel(pfns_pkg::GRAD_SY[g_ff[dc]], dy);

   assign p_raw   = rq_p + Q_HALF;
   assign p_clamp = p_raw[QW-1] ? '0 : ((p_raw > Q_ONE) ? Q_ONE : p_raw);

   assign oc_raw   = req_tdata[91:88];
   assign last_oct = (oct_ff == NW'(n_ff - 1'b1));
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign mean = 48'((acc_ff + 80'(64'h8000_0000)) >> 32);
   assign conv = ((64'(mean) + OUT_RND) >> SH_DN) << SH_UP;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         pfns_pkg::ST_SCALE: begin
            mul_a = (step_ff == pfns_pkg::S_SEED) ? 34'(cx_ff) : 34'(cy_ff);
            mul_b = {10'b0, freq_ff};
         end
         pfns_pkg::ST_OCT: begin
            case (step_ff)
               pfns_pkg::S_SEED: begin
                  mul_a = {2'b00, seed_ff};
                  mul_b = {2'b00, pfns_pkg::HASH_MUL_SEED};
               end
               pfns_pkg::S_HX0: begin
                  mul_a = {2'b00, x0};
                  mul_b = {2'b00, pfns_pkg::HASH_MUL_X};
               end
               pfns_pkg::S_HX1: begin
                  mul_a = {2'b00, x0 + 32'd1};
                  mul_b = {2'b00, pfns_pkg::HASH_MUL_X};
               end
               pfns_pkg::S_HY0: begin
                  mul_a = {2'b00, y0};
                  mul_b = {2'b00, pfns_pkg::HASH_MUL_Y};
               end
               pfns_pkg::S_HY1: begin
                  mul_a = {2'b00, y0 + 32'd1};
                  mul_b = {2'b00, pfns_pkg::HASH_MUL_Y};
               end
               pfns_pkg::S_HASH0, pfns_pkg::S_HASH1,
               pfns_pkg::S_HASH2, pfns_pkg::S_HASH3: begin
                  mul_a = {2'b00, hmix};
                  mul_b = {2'b00, pfns_pkg::HASH_MUL_MIX};
               end
               pfns_pkg::S_DIAG0, pfns_pkg::S_DIAG1,
               pfns_pkg::S_DIAG2, pfns_pkg::S_DIAG3: begin
                  mul_a = 34'(Q_DIAG);
                  mul_b = 34'(dot);
               end
               pfns_pkg::S_FX2, pfns_pkg::S_FY2: begin
                  mul_a = 34'(fade_t);
                  mul_b = 34'(fade_t);
               end
               pfns_pkg::S_FX3, pfns_pkg::S_FY3: begin
                  mul_a = 34'(t2_ff);
                  mul_b = 34'(fade_t);
               end
               pfns_pkg::S_FXI, pfns_pkg::S_FYI: begin
                  mul_a = 34'(fade_t);
                  mul_b = 34'(6 * fade_t - 15 * Q_ONE);
               end
               pfns_pkg::S_FXU, pfns_pkg::S_FYV: begin
                  mul_a = 34'(t3_ff);
                  mul_b = 34'(inner_ff);
               end
               pfns_pkg::S_BLA: begin
                  mul_a = 34'(u_ff);
                  mul_b = 34'(d_ff[1] - d_ff[0]);
               end
               pfns_pkg::S_BLB: begin
                  mul_a = 34'(u_ff);
                  mul_b = 34'(d_ff[3] - d_ff[2]);
               end
               pfns_pkg::S_BLR: begin
                  mul_a = 34'(v_ff);
                  mul_b = 34'(b_ff - a_ff);
               end
               default: begin
                  mul_a = 34'(r_ff);
                  mul_b = 34'(Q_DIAG);
               end
            endcase
         end
         pfns_pkg::ST_MEAN: begin
            if (step_ff == pfns_pkg::S_SEED) begin
               mul_a = 34'(sum_ff[pfns_pkg::SUM_SPLIT-1:0]);
            end else begin
               mul_a = 34'(sum_ff[pfns_pkg::SUM_W-1:pfns_pkg::SUM_SPLIT]);
            end
            mul_b = {1'b0, pfns_pkg::RECIP_TABLE[4'(n_ff - 1'b1)]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      n_in         = n_ff;
      oct_in       = oct_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         pfns_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = pfns_pkg::ST_SCALE;
               step_in  = pfns_pkg::S_SEED;
               oct_in   = '0;
               if (oc_raw == 4'd0) begin
                  n_in = NW'(1);
               end else if (int'(oc_raw) > MAX_OCTAVES) begin
                  n_in = NW'(MAX_OCTAVES);
               end else begin
                  n_in = NW'(oc_raw);
               end
            end
         end
         pfns_pkg::ST_SCALE: begin
            if (step_ff == pfns_pkg::S_SEED) begin
               step_in = pfns_pkg::S_HX0;
            end else begin
               state_in = pfns_pkg::ST_OCT;
               step_in  = pfns_pkg::S_SEED;
            end
         end
         pfns_pkg::ST_OCT: begin
            if (step_ff == pfns_pkg::S_OUT) begin
               step_in = pfns_pkg::S_SEED;
               oct_in  = NW'(oct_ff + 1'b1);
               if (last_oct) begin
                  state_in = pfns_pkg::ST_MEAN;
               end
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         pfns_pkg::ST_MEAN: begin
            if (step_ff == pfns_pkg::S_SEED) begin
               step_in = pfns_pkg::S_HX0;
            end else begin
               state_in = pfns_pkg::ST_DONE;
            end
         end
         pfns_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in     = pfns_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = pfns_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfns_pkg::ST_IDLE;
         step_ff      <= pfns_pkg::S_SEED;
         n_ff         <= NW'(1);
         oct_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         n_ff         <= n_in;
         oct_ff       <= oct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         pfns_pkg::ST_IDLE: begin
            cx_ff   <= req_tdata[31:0];
            cy_ff   <= req_tdata[63:32];
            freq_ff <= req_tdata[87:64];
            seed_ff <= req_tdata[123:92];
            sum_ff  <= '0;
         end
         pfns_pkg::ST_SCALE: begin
            if (step_ff == pfns_pkg::S_SEED) begin
               sx_ff <= scaled[63:0];
            end else begin
               sy_ff <= scaled[63:0];
            end
         end
         pfns_pkg::ST_OCT: begin
            case (step_ff)
               pfns_pkg::S_SEED: hs_ff    <= mul_p[31:0];
               pfns_pkg::S_HX0:  hx_ff[0] <= mul_p[31:0];
               pfns_pkg::S_HX1:  hx_ff[1] <= mul_p[31:0];
               pfns_pkg::S_HY0:  hy_ff[0] <= mul_p[31:0];
               pfns_pkg::S_HY1:  hy_ff[1] <= mul_p[31:0];
               pfns_pkg::S_HASH0, pfns_pkg::S_HASH1,
               pfns_pkg::S_HASH2, pfns_pkg::S_HASH3: begin
                  g_ff[hc] <= mul_p[2:0] ^ mul_p[18:16];
               end
               pfns_pkg::S_DIAG0, pfns_pkg::S_DIAG1,
               pfns_pkg::S_DIAG2, pfns_pkg::S_DIAG3: begin
                  d_ff[dc] <= g_ff[dc][2] ? rq_p : dot;
               end
               pfns_pkg::S_FX2, pfns_pkg::S_FY2: t2_ff <= rq_p;
               pfns_pkg::S_FX3, pfns_pkg::S_FY3: t3_ff <= rq_p;
               pfns_pkg::S_FXI, pfns_pkg::S_FYI: inner_ff <= QW'(rq_p + 10 * Q_ONE);
               pfns_pkg::S_FXU: u_ff <= rq_p;
               pfns_pkg::S_FYV: v_ff <= rq_p;
               pfns_pkg::S_BLA: a_ff <= d_ff[0] + rq_p;
               pfns_pkg::S_BLB: b_ff <= d_ff[2] + rq_p;
               pfns_pkg::S_BLR: r_ff <= a_ff + rq_p;
               default: begin
                  sum_ff  <= (sum_ff << 1) + pfns_pkg::SUM_W'(p_clamp);
                  sx_ff   <= sx_ff << 1;
                  sy_ff   <= sy_ff << 1;
                  seed_ff <= seed_ff + pfns_pkg::OCTAVE_SEED_STEP;
               end
            endcase
         end
         pfns_pkg::ST_MEAN: begin
            if (step_ff == pfns_pkg::S_SEED) begin
               acc_ff <= 80'(unsigned'(mul_p));
            end else begin
               acc_ff <= acc_ff + (80'(unsigned'(mul_p)) << pfns_pkg::SUM_SPLIT);
            end
         end
         default: begin
            if (rsp_free) begin
               rsp_data_ff <= (conv > 64'd65535) ? 16'hFFFF : conv[15:0];
            end
         end
      endcase
   end

   assign req_tready = (state_ff == pfns_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_oct_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfns_pkg::ST_OCT) |-> (oct_ff < n_ff))
      else $error("octave counter ran past the octave count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (n_ff >= NW'(1)) && (int'(n_ff) <= MAX_OCTAVES))
      else $error("octave count out of range");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= pfns_pkg::S_OUT)
      else $error("step counter out of range");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfns_pkg::ST_DONE && rsp_free) |=> rsp_valid_ff)
      else $error("finished word not presented");

endmodule
